>>> rtl/lfu_pkg.sv
`default_nettype none

package lfu_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int KEY_W           = 32;
    localparam int CFG_W           = 5;
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SWEEP,
        ST_APPLY
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TOUCH,
        OP_INSERT
    } cmd_op_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        cmd_op_t          op;
        logic             is_put;
        logic             dec_en;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] value;
    } cmd_t;

endpackage

`default_nettype wire

>>> rtl/lfu_cell.sv
`default_nettype none

module lfu_cell
    import lfu_pkg::*;
#(
    parameter int IDX         = 0,
    parameter int IW          = 4,
    parameter int RW          = 4,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  cmd_t                   cmd,
    input  wire                    sel,
    input  wire  [RW-1:0]          base_rank,
    input  wire  [RW-1:0]          new_rank,
    input  wire  [KEY_W-1:0]       req_key,
    output logic                   hit,
    output logic [KEY_W-1:0]       value,
    output logic [RW-1:0]          rank,
    output logic                   valid,
    input  wire                    chain_in_valid,
    input  wire  [COUNT_WIDTH-1:0] chain_in_cnt,
    input  wire  [RW-1:0]          chain_in_rank,
    input  wire  [IW-1:0]          chain_in_idx,
    input  wire  [KEY_W-1:0]       chain_in_key,
    output logic                   chain_out_valid,
    output logic [COUNT_WIDTH-1:0] chain_out_cnt,
    output logic [RW-1:0]          chain_out_rank,
    output logic [IW-1:0]          chain_out_idx,
    output logic [KEY_W-1:0]       chain_out_key
);

    logic                   valid_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [KEY_W-1:0]       value_reg;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [RW-1:0]          rank_reg;
    logic                   self_better;

    assign hit   = valid_reg && (key_reg == req_key);
    assign value = value_reg;
    assign rank  = rank_reg;
    assign valid = valid_reg;

    // This cell wins over the running minimum on lower count, then lower rank.
    assign self_better = valid_reg && (!chain_in_valid || (cnt_reg < chain_in_cnt) ||
                         ((cnt_reg == chain_in_cnt) && (rank_reg < chain_in_rank)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= 1'b0;
            chain_out_valid <= 1'b0;
        end
        else
        begin
            chain_out_valid <= self_better || chain_in_valid;
            if (cmd.op == OP_INSERT && sel)
                valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (self_better)
        begin
            chain_out_cnt  <= cnt_reg;
            chain_out_rank <= rank_reg;
            chain_out_idx  <= IW'(IDX);
            chain_out_key  <= key_reg;
        end
        else
        begin
            chain_out_cnt  <= chain_in_cnt;
            chain_out_rank <= chain_in_rank;
            chain_out_idx  <= chain_in_idx;
            chain_out_key  <= chain_in_key;
        end

        if (cmd.op != OP_NONE)
        begin
            if (sel)
            begin
                rank_reg <= new_rank;
                if (cmd.op == OP_INSERT)
                begin
                    key_reg   <= cmd.key;
                    value_reg <= cmd.value;
                    cnt_reg   <= COUNT_WIDTH'(1);
                end
                else
                begin
                    if (cmd.is_put)
                        value_reg <= cmd.value;
                    if (cnt_reg != {COUNT_WIDTH{1'b1}})
                        cnt_reg <= cnt_reg + 1'b1;
                end
            end
            else if (valid_reg && cmd.dec_en && (rank_reg > base_rank))
            begin
                rank_reg <= rank_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/lfu_cache_table.sv
// Channel   Direction  Payload
// s_axis    in         tuser: kind; tdata: key[31:0], write_value[63:32]
// m_axis    out        tuser: found[0], evicted[1]; tdata: read_value[31:0],
//                      evicted_key[63:32]
// cfg       in         cfg_wen, cfg_wdata: capacity_in_use
//
// One request is handled at a time. A hit, a get miss or a put into a free
// slot passes through the transfer, the key compare, and the result with the
// table update. A put that must evict first waits in the sweep state while
// the victim search ripples through the row of cells. Reset clears all valid
// bits and the occupancy count; the capacity register resets to 16. A result
// held back by m_tready stalls the table update, and a new request is taken
// once the block is idle.

`default_nettype none

module lfu_cache_table
    import lfu_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               s_tvalid,
    output logic              s_tready,
    input  wire  [63:0]       s_tdata,   // key, write_value
    input  wire               s_tuser,   // kind
    output logic              m_tvalid,
    input  wire               m_tready,
    output logic [63:0]       m_tdata,   // read_value, evicted_key
    output logic [1:0]        m_tuser,   // found, evicted
    input  wire               cfg_wen,
    input  wire  [CFG_W-1:0]  cfg_wdata
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RW = IW;
    localparam int OW = $clog2(CAPACITY + 1);
    localparam int LW = (OW > CFG_W) ? OW : CFG_W;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]       cap_reg;
    logic [OW-1:0]          occ_reg;
    logic [IW:0]            sweep_reg;
    logic                   kind_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [KEY_W-1:0]       wval_reg;
    logic                   found_reg;
    logic [CAPACITY-1:0]    hit_vec_reg;
    logic [RW-1:0]          hit_rank_reg;
    logic [KEY_W-1:0]       rval_reg;
    logic                   full_reg;

    // Per-cell status and chain wiring.
    logic [CAPACITY-1:0]    hit_vec;
    logic [CAPACITY-1:0]    valid_vec;
    logic [CAPACITY-1:0]    sel_vec;
    logic [KEY_W-1:0]       cell_value [CAPACITY];
    logic [RW-1:0]          cell_rank  [CAPACITY];
    logic                   ch_valid [CAPACITY+1];
    logic [COUNT_WIDTH-1:0] ch_cnt   [CAPACITY+1];
    logic [RW-1:0]          ch_rank  [CAPACITY+1];
    logic [IW-1:0]          ch_idx   [CAPACITY+1];
    logic [KEY_W-1:0]       ch_key   [CAPACITY+1];

    logic [KEY_W-1:0]       rval_any;
    logic [RW-1:0]          hrank_any;
    logic [CAPACITY-1:0]    free_vec;
    logic [CAPACITY-1:0]    first_free;
    logic [LW-1:0]          occ_x;
    logic [LW-1:0]          cap_eff;
    logic                   full_now;
    logic [OW-1:0]          occ_m1;

    cmd_t                   cmd;
    logic [RW-1:0]          base_rank;
    logic [RW-1:0]          new_rank;
    logic                   fire;
    logic                   ev_flag;
    logic                   occ_inc;

    // Head of the chain: no candidate yet.
    assign ch_valid[0] = 1'b0;
    assign ch_cnt[0]   = '0;
    assign ch_rank[0]  = '0;
    assign ch_idx[0]   = '0;
    assign ch_key[0]   = '0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        lfu_cell #(
            .IDX         (g),
            .IW          (IW),
            .RW          (RW),
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .cmd             (cmd),
            .sel             (sel_vec[g]),
            .base_rank       (base_rank),
            .new_rank        (new_rank),
            .req_key         (key_reg),
            .hit             (hit_vec[g]),
            .value           (cell_value[g]),
            .rank            (cell_rank[g]),
            .valid           (valid_vec[g]),
            .chain_in_valid  (ch_valid[g]),
            .chain_in_cnt    (ch_cnt[g]),
            .chain_in_rank   (ch_rank[g]),
            .chain_in_idx    (ch_idx[g]),
            .chain_in_key    (ch_key[g]),
            .chain_out_valid (ch_valid[g+1]),
            .chain_out_cnt   (ch_cnt[g+1]),
            .chain_out_rank  (ch_rank[g+1]),
            .chain_out_idx   (ch_idx[g+1]),
            .chain_out_key   (ch_key[g+1])
        );
    end

    // Keys are unique among valid entries, so at most one cell hits and the
    // hit value and rank can be merged with a plain OR.
    always_comb
    begin
        rval_any  = '0;
        hrank_any = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (hit_vec[i])
            begin
                rval_any  = rval_any | cell_value[i];
                hrank_any = hrank_any | cell_rank[i];
            end
        end
    end

    // Lowest free slot, isolated as the lowest set bit.
    assign free_vec   = ~valid_vec;
    assign first_free = free_vec & (~free_vec + 1'b1);

    // Effective limit: zero acts as one, anything above CAPACITY as CAPACITY.
    assign occ_x = LW'(occ_reg);
    always_comb
    begin
        cap_eff = LW'(cap_reg);
        if (cap_reg == '0)
            cap_eff = LW'(1);
        else if (cap_eff > LW'(CAPACITY))
            cap_eff = LW'(CAPACITY);
    end
    assign full_now = (occ_x >= cap_eff);
    assign occ_m1   = occ_reg - 1'b1;

    assign fire     = (state_reg == ST_APPLY) && (!m_tvalid || m_tready);
    assign s_tready = (state_reg == ST_IDLE);

    // Table update, issued in the cycle the result is written out.
    always_comb
    begin
        cmd.op     = OP_NONE;
        cmd.is_put = kind_reg;
        cmd.dec_en = 1'b0;
        cmd.key    = key_reg;
        cmd.value  = wval_reg;
        sel_vec    = '0;
        base_rank  = '0;
        new_rank   = occ_m1[RW-1:0];
        ev_flag    = 1'b0;
        occ_inc    = 1'b0;
        if (fire)
        begin
            if (found_reg)
            begin
                cmd.op     = OP_TOUCH;
                cmd.dec_en = 1'b1;
                sel_vec    = hit_vec_reg;
                base_rank  = hit_rank_reg;
            end
            else if (kind_reg)
            begin
                cmd.op = OP_INSERT;
                if (full_reg)
                begin
                    // Victim leaves, new key takes its slot at the top rank.
                    cmd.dec_en = 1'b1;
                    ev_flag    = 1'b1;
                    base_rank  = ch_rank[CAPACITY];
                    for (int i = 0; i < CAPACITY; i++)
                        sel_vec[i] = (ch_idx[CAPACITY] == IW'(i));
                end
                else
                begin
                    sel_vec  = first_free;
                    new_rank = occ_reg[RW-1:0];
                    occ_inc  = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                if (kind_reg && !(|hit_vec) && full_now)
                    state_next = ST_SWEEP;
                else
                    state_next = ST_APPLY;
            end
            ST_SWEEP:
            begin
                if (sweep_reg == (IW+1)'(CAPACITY))
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (fire)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg   <= CAP_RESET;
            occ_reg   <= '0;
            sweep_reg <= '0;
            m_tvalid  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wen)
                cap_reg <= cfg_wdata;
            if (occ_inc)
                occ_reg <= occ_reg + 1'b1;
            if (state_reg == ST_SWEEP)
                sweep_reg <= sweep_reg + 1'b1;
            else
                sweep_reg <= '0;
            if (fire)
                m_tvalid <= 1'b1;
            else if (m_tready)
                m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            kind_reg <= s_tuser;
            key_reg  <= s_tdata[31:0];
            wval_reg <= s_tdata[63:32];
        end
        if (state_reg == ST_LOOK)
        begin
            found_reg    <= |hit_vec;
            hit_vec_reg  <= hit_vec;
            hit_rank_reg <= hrank_any;
            rval_reg     <= rval_any;
            full_reg     <= full_now;
        end
        if (fire)
        begin
            m_tuser[0]     <= found_reg;
            m_tuser[1]     <= ev_flag;
            m_tdata[31:0]  <= (found_reg && !kind_reg) ? rval_reg : '0;
            m_tdata[63:32] <= ev_flag ? ch_key[CAPACITY] : '0;
        end
    end

endmodule

`default_nettype wire

>>> test/lfu_cache_checker.sv
module lfu_cache_checker
    import lfu_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [63:0] s_tdata,
    input  wire         s_tuser,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [63:0] m_tdata,
    input  wire  [1:0]  m_tuser,
    input  wire         cfg_wen,
    input  wire  [CFG_W-1:0] cfg_wdata,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = CAPACITY_DEF;
    localparam int CMAX = (1 << COUNT_WIDTH_DEF) - 1;

    typedef struct {
        logic        found;
        logic [31:0] read_value;
        logic        evicted;
        logic [31:0] evicted_key;
    } lookup_result_t;

    logic        slot_valid [SLOTS];
    logic [31:0] slot_key   [SLOTS];
    logic [31:0] slot_value [SLOTS];
    int          slot_uses  [SLOTS];
    int          slot_rank  [SLOTS];
    int          occupancy;
    logic [CFG_W-1:0] cap_reg;
    lookup_result_t   pending_results [$];

    // Close the gap left by slot s in the recency order.
    function automatic void drop_rank(int s);
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && i != s && slot_rank[i] > slot_rank[s])
                slot_rank[i]--;
    endfunction

    function automatic lookup_result_t serve_request(logic is_put, logic [31:0] key,
                                                     logic [31:0] wval);
        lookup_result_t r;
        int hit;
        int lim;
        int slot;
        int v;
        r = '{1'b0, 32'd0, 1'b0, 32'd0};
        hit = -1;
        for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && slot_valid[i] && slot_key[i] == key) hit = i;
        if (hit >= 0) begin
            r.found = 1'b1;
            if (!is_put) r.read_value = slot_value[hit];
            else slot_value[hit] = wval;
            if (slot_uses[hit] < CMAX) slot_uses[hit]++;
            drop_rank(hit);
            slot_rank[hit] = occupancy - 1;
        end
        else if (is_put) begin
            lim = (cap_reg == 0) ? 1 : (cap_reg > SLOTS ? SLOTS : cap_reg);
            slot = -1;
            if (occupancy >= lim) begin
                v = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (slot_valid[i] && (v < 0 || slot_uses[i] < slot_uses[v] ||
                        (slot_uses[i] == slot_uses[v] && slot_rank[i] < slot_rank[v])))
                        v = i;
                if (v >= 0) begin
                    r.evicted = 1'b1;
                    r.evicted_key = slot_key[v];
                    drop_rank(v);
                    slot_valid[v] = 1'b0;
                    occupancy--;
                    slot = v;
                end
            end
            for (int i = 0; i < SLOTS; i++)
                if (slot < 0 && !slot_valid[i]) slot = i;
            slot_valid[slot] = 1'b1;
            slot_key[slot] = key;
            slot_value[slot] = wval;
            slot_uses[slot] = 1;
            slot_rank[slot] = occupancy;
            occupancy++;
        end
        return r;
    endfunction

    assign pending_count = pending_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
            occupancy = 0;
            cap_reg = CAP_RESET;
            fail_count = 0;
            pending_results.delete();
        end
        else
        begin
            if (cfg_wen) cap_reg = cfg_wdata;
            if (s_tvalid && s_tready)
                pending_results.push_back(serve_request(s_tuser, s_tdata[31:0],
                                                        s_tdata[63:32]));
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tuser[0] !== want.found)
                    begin
                        $error("found: expected %0b, got %0b", want.found, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tdata[31:0] !== want.read_value)
                    begin
                        $error("read_value: expected %h, got %h", want.read_value,
                               m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tuser[1] !== want.evicted)
                    begin
                        $error("evicted: expected %0b, got %0b", want.evicted, m_tuser[1]);
                        fail_count++;
                    end
                    if (m_tdata[63:32] !== want.evicted_key)
                    begin
                        $error("evicted_key: expected %h, got %h", want.evicted_key,
                               m_tdata[63:32]);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

>>> test/tb_lfu_cache_table.sv
module tb_lfu_cache_table;
    import lfu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;    // key[31:0], write_value[63:32]
    logic        s_tuser;    // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;    // read_value[31:0], evicted_key[63:32]
    logic [1:0]  m_tuser;    // found[0], evicted[1]
    logic        cfg_wen;
    logic [CFG_W-1:0] cfg_wdata;
    int          fail_count;
    int          pending_count;
    // When set, both sides run without any idle cycles.
    bit          no_idle;
    // Small pool of keys so that hits and evictions are frequent.
    logic [31:0] key_pool [24];

    lfu_cache_table u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
    );

    lfu_cache_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // The receiver stalls with a probability of about 36 percent unless idling is switched off.
    always @(posedge clk)
        m_tready <= no_idle || ($urandom_range(99) >= 36);

    // Offers one request and holds it until the block takes the transfer.
    // The block is busy in its compare and result states after a transfer, so
    // dropping tvalid at the end costs no throughput.
    task automatic send_request(logic kind, logic [31:0] key, logic [31:0] wval);
        while (!no_idle && $urandom_range(99) < 36) @(posedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {wval, key};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Capacity changes only while the table is idle; an eviction walks the row,
    // so the task also waits out any tail of the last request.
    task automatic set_capacity(logic [CFG_W-1:0] cap);
        while (pending_count != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    initial
    begin
        int pick;
        logic [CFG_W-1:0] cap;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_GET;
        m_tready = 1'b0;
        cfg_wen = 1'b0;
        cfg_wdata = '0;
        no_idle = 1'b0;
        for (int i = 0; i < 24; i++) key_pool[i] = $urandom();
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a get miss on an empty table, puts at the key and value
        // extremes, hits, an overwrite, and evictions with ties on count.
        send_request(KIND_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(KIND_GET, 32'h8000_0000, 32'h0);
        send_request(KIND_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_GET, 32'h7FFF_FFFF, 32'h0);
        set_capacity(5'd2);
        send_request(KIND_PUT, 32'h0, 32'h1234_5678);
        send_request(KIND_PUT, 32'hFFFF_FFFF, 32'h0);
        send_request(KIND_GET, 32'h0, 32'h0);
        // Capacity zero behaves as one entry.
        set_capacity(5'd0);
        send_request(KIND_PUT, 32'h5555_AAAA, 32'hAAAA_5555);
        send_request(KIND_PUT, 32'hAAAA_5555, 32'h5555_AAAA);
        send_request(KIND_GET, 32'hAAAA_5555, 32'h0);
        // Values above the table size behave as the full table.
        set_capacity(5'd31);
        for (int i = 0; i < 18; i++)
            send_request(KIND_PUT, key_pool[i], $urandom());

        // Random phases through several capacities, extremes included.
        for (int phase = 0; phase < 9; phase++)
        begin
            case (phase)
                0: cap = 5'd16;
                1: cap = 5'd1;
                2: cap = 5'd0;
                3: cap = 5'd31;
                default: cap = CFG_W'($urandom_range(31));
            endcase
            set_capacity(cap);
            no_idle = (phase == 4);
            for (int n = 0; n < 200; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 85)
                    send_request(1'($urandom_range(1)), key_pool[$urandom_range(23)],
                                 $urandom());
                else
                    send_request(1'($urandom_range(1)), $urandom(), $urandom());
            end
            no_idle = 1'b0;
        end

        // A final burst of puts on the full table with no idling.
        set_capacity(5'd16);
        no_idle = 1'b1;
        for (int n = 0; n < 40; n++)
            send_request(KIND_PUT, key_pool[$urandom_range(23)], $urandom());
        no_idle = 1'b0;

        while (pending_count != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end
endmodule
